// File: rtl/core/spq_pkg.sv
package spq_pkg;

  localparam int KEY_W   = 16;
  localparam int PAY_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // request kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
  } res_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// File: rtl/core/spq_ifs.sv
interface spq_req_if import spq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [KEY_W-1:0] arrival_key;
  logic [PAY_W-1:0] payload;

  modport source (output valid, kind, arrival_key, payload, input ready);
  modport sink   (input valid, kind, arrival_key, payload, output ready);
endinterface

interface spq_res_if import spq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   out_key;
  logic [PAY_W-1:0]   out_payload;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, out_key, out_payload, status, entry_count, input ready);
  modport sink   (input valid, out_key, out_payload, status, entry_count, output ready);
endinterface

// File: rtl/core/spq_store.sv
module spq_store import spq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata_r
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/spq_ctrl.sv
module spq_ctrl import spq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  req_t          req,
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res,
  output mem_ctl_t      mem_ctl,
  output logic [AW-1:0] waddr,
  output entry_t        wdata,
  output logic [AW-1:0] raddr,
  input  entry_t        rdata
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INSERT   = 3'd1;
  localparam logic [2:0] S_REM_HEAD = 3'd2;
  localparam logic [2:0] S_REMOVE   = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  entry_t            new_r, new_nxt;
  entry_t            head_r, head_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    new_r    <= new_nxt;
    head_r   <= head_nxt;
    status_r <= status_nxt;
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = '{key: head_r.key, payload: head_r.payload, status: status_r,
                       count: COUNT_W'(count_r)};

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    new_nxt    = new_r;
    head_nxt   = head_r;
    status_nxt = status_r;
    mem_ctl    = '0;
    waddr      = ptr_r;
    wdata      = new_r;
    raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          new_nxt    = '{key: req.key, payload: req.payload};
          head_nxt   = '0;
          status_nxt = ST_OK;
          if (req.kind == KIND_INSERT) begin
            if (count_r == CW'(DEPTH)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else if (count_r == '0) begin
              mem_ctl.we = 1'b1;
              waddr      = '0;
              wdata      = '{key: req.key, payload: req.payload};
              count_nxt  = count_r + CW'(1);
              state_nxt  = S_DONE;
            end else begin
              // fetch the tail entry, then walk toward the head
              mem_ctl.re = 1'b1;
              raddr      = AW'(count_r - CW'(1));
              ptr_nxt    = AW'(count_r);
              state_nxt  = S_INSERT;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              mem_ctl.re = 1'b1;
              raddr      = '0;
              state_nxt  = S_REM_HEAD;
            end
          end
        end
      end

      S_INSERT: begin
        // rdata holds the entry just below ptr_r
        if (ptr_r == '0) begin
          mem_ctl.we = 1'b1;
          waddr      = '0;
          count_nxt  = count_r + CW'(1);
          state_nxt  = S_DONE;
        end else if (rdata.key > new_r.key) begin
          mem_ctl.we = 1'b1;
          waddr      = ptr_r;
          wdata      = rdata;
          ptr_nxt    = ptr_r - 1'b1;
          if (ptr_r > AW'(1)) begin
            mem_ctl.re = 1'b1;
            raddr      = ptr_r - 1'b1 - 1'b1;
          end
        end else begin
          mem_ctl.we = 1'b1;
          waddr      = ptr_r;
          count_nxt  = count_r + CW'(1);
          state_nxt  = S_DONE;
        end
      end

      S_REM_HEAD: begin
        head_nxt = rdata;
        if (count_r == CW'(1)) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          mem_ctl.re = 1'b1;
          raddr      = AW'(1);
          ptr_nxt    = AW'(1);
          state_nxt  = S_REMOVE;
        end
      end

      S_REMOVE: begin
        // move entry ptr_r up one place
        mem_ctl.we = 1'b1;
        waddr      = ptr_r - 1'b1;
        wdata      = rdata;
        if (CW'(ptr_r) + CW'(1) == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          mem_ctl.re = 1'b1;
          raddr      = ptr_r + 1'b1;
          ptr_nxt    = ptr_r + 1'b1;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/sorted_insert_priority_queue.sv
// Channel  Dir  Interface   Payload
// in_ch    in   spq_req_if  kind, arrival_key, payload
// out_ch   out  spq_res_if  out_key, out_payload, status, entry_count
//
// Insert moves each stored entry above its slot along one place; remove moves
// every entry behind the head up one place; a dropped request (full or empty queue)
// goes straight to the done state.
// The store walk has one read port, one write port and one move per cycle.
// Reset (rst_n low, synchronous) empties the queue; the store itself is not cleared.
// A result waits in the output register while the next request is taken.
// A stalled output holds the sequencer in its done state until the register drains.
module sorted_insert_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  spq_req_if.sink    in_ch,
  spq_res_if.source  out_ch
);

  localparam int AW = $clog2(DEPTH);

  req_t          req;
  res_t          res;
  logic          res_valid;
  logic          res_ready;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  entry_t        wdata;
  entry_t        rdata;

  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  assign req = '{kind: in_ch.kind, key: in_ch.arrival_key, payload: in_ch.payload};

  spq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_ch.valid),
    .req_ready (in_ch.ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_ctl   (mem_ctl),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  spq_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  // load the output register when empty or draining this cycle
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_key     = out_r.key;
  assign out_ch.out_payload = out_r.payload;
  assign out_ch.status      = out_r.status;
  assign out_ch.entry_count = out_r.count;

endmodule

// File: rtl/core/spq_checker.sv
module spq_checker import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [KEY_W-1:0]   out_key,
  input logic [PAY_W-1:0]   out_payload,
  input logic [STAT_W-1:0]  status,
  input logic [COUNT_W-1:0] entry_count
);

  // the sequencer is busy in the cycle after it takes a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken on consecutive cycles");

  // a failed request never returns entry data
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> out_key == '0 && out_payload == '0)
    else $error("error result carries entry data");

  // for DEPTH below 32, the count stays within the queue size, and full/empty codes agree with it
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (DEPTH < 32) |->
      (32'(entry_count) <= DEPTH) &&
      (status != ST_EMPTY || entry_count == '0) &&
      (status != ST_FULL || 32'(entry_count) == DEPTH))
    else $error("entry count inconsistent with status");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key) &&
      $stable(out_payload) && $stable(status) && $stable(entry_count))
    else $error("stalled result changed");

endmodule

bind sorted_insert_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_key     (out_ch.out_key),
  .out_payload (out_ch.out_payload),
  .status      (out_ch.status),
  .entry_count (out_ch.entry_count)
);
